[src/scfe_pkg.sv]
// ----------------------------------------------------------------------------
// scfe_pkg
// Shared types and constants for the serial command frame encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package scfe_pkg;

    localparam int unsigned BYTE_W = 8;

    // Fixed frame bytes and length overheads
    localparam logic [BYTE_W-1:0] HEAD_BYTE    = 8'hAA;
    localparam logic [BYTE_W-1:0] TAIL_BYTE    = 8'hDD;
    localparam logic [BYTE_W-1:0] ERR_BYTE     = 8'h00;
    localparam logic [BYTE_W-1:0] LEN_OVERHEAD = 8'd3;
    localparam logic [BYTE_W:0]   FRAME_OVERHEAD = 9'd6;

    // Configuration register indexes and reset values
    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_HDR_INDEX       = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_FRAME_BYTES = 8'd1;
    localparam logic [BYTE_W-1:0] HDR_INDEX_RESET       = 8'd1;
    localparam logic [BYTE_W-1:0] MAX_FRAME_BYTES_RESET = 8'd240;

    // Descriptor queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_START   = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } desc_kind_t;

    // One classified input word, as handed from front to back
    typedef struct packed {
        desc_kind_t        kind;
        logic              has_pb;   // start word carries a payload byte
        logic              last;     // checksum and tail follow this word
        logic [BYTE_W-1:0] flen;
        logic [BYTE_W-1:0] idx;
        logic [BYTE_W-1:0] cmd;
        logic [BYTE_W-1:0] pb;
        logic [BYTE_W-1:0] sum;
    } desc_t;

    // Front-to-queue push group
    typedef struct packed {
        logic  valid;
        desc_t desc;
    } push_t;

    // Queue-to-back head group
    typedef struct packed {
        logic  valid;
        desc_t desc;
    } head_t;

endpackage

`default_nettype wire

[src/scfe_if.sv]
// ----------------------------------------------------------------------------
// scfe_if
// Handshake channels of the frame encoder: input words, output bytes, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface scfe_item_if;
    import scfe_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] command;
    logic [BYTE_W-1:0] payload_len;
    logic [BYTE_W-1:0] payload_byte;

    modport source (output valid, command, payload_len, payload_byte, input ready);
    modport sink   (input valid, command, payload_len, payload_byte, output ready);
endinterface

interface scfe_result_if;
    import scfe_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              frame_done;
    logic              error;

    modport source (output valid, out_byte, frame_done, error, input ready);
    modport sink   (input valid, out_byte, frame_done, error, output ready);
endinterface

interface scfe_cfg_if;
    import scfe_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [BYTE_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[src/scfe_front.sv]
// ----------------------------------------------------------------------------
// scfe_front
// Accepts input words, tracks frame state and classifies each word.
// ----------------------------------------------------------------------------
`default_nettype none

module scfe_front (
    input  wire                  clk,
    input  wire                  rst_n,
    scfe_item_if.sink            item,
    scfe_cfg_if.sink             cfg,
    input  wire                  queue_full,
    output scfe_pkg::push_t      push
);
    import scfe_pkg::*;

    logic [BYTE_W-1:0] hdr_index_reg;
    logic [BYTE_W-1:0] max_frame_reg;
    logic [BYTE_W-1:0] running_sum_reg, running_sum_next;
    logic [BYTE_W-1:0] bytes_left_reg,  bytes_left_next;

    logic              accept;
    logic [BYTE_W-1:0] flen;
    logic [BYTE_W-1:0] base_sum;
    logic [BYTE_W-1:0] mid_sum;
    logic              oversize;
    desc_t             desc;

    assign cfg.ready  = 1'b1;
    assign item.ready = !queue_full;
    assign accept     = item.valid && !queue_full;

    assign flen     = item.payload_len + LEN_OVERHEAD;
    assign base_sum = flen + hdr_index_reg + item.command;
    assign mid_sum  = running_sum_reg + item.payload_byte;
    assign oversize = ({1'b0, item.payload_len} + FRAME_OVERHEAD) > {1'b0, max_frame_reg};

    always_comb
    begin
        desc             = '0;
        desc.flen        = flen;
        desc.idx         = hdr_index_reg;
        desc.cmd         = item.command;
        desc.pb          = item.payload_byte;
        running_sum_next = running_sum_reg;
        bytes_left_next  = bytes_left_reg;
        if (bytes_left_reg != '0)
        begin
            // continuation byte of a frame in progress
            desc.kind        = KIND_PAYLOAD;
            desc.has_pb      = 1'b1;
            desc.last        = (bytes_left_reg == 8'd1);
            desc.sum         = mid_sum;
            bytes_left_next  = bytes_left_reg - 8'd1;
            running_sum_next = desc.last ? '0 : mid_sum;
        end
        else if (oversize)
        begin
            desc.kind = KIND_ERROR;
        end
        else
        begin
            desc.kind   = KIND_START;
            desc.has_pb = (item.payload_len != '0);
            desc.last   = (item.payload_len <= 8'd1);
            desc.sum    = desc.has_pb ? (base_sum + item.payload_byte) : base_sum;
            bytes_left_next  = desc.has_pb ? (item.payload_len - 8'd1) : '0;
            running_sum_next = desc.last ? '0 : desc.sum;
        end
    end

    assign push.valid = accept;
    assign push.desc  = desc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_index_reg   <= HDR_INDEX_RESET;
            max_frame_reg   <= MAX_FRAME_BYTES_RESET;
            running_sum_reg <= '0;
            bytes_left_reg  <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_HDR_INDEX:       hdr_index_reg <= cfg.data;
                    CFG_MAX_FRAME_BYTES: max_frame_reg <= cfg.data;
                    default:             ;
                endcase
            end
            if (accept)
            begin
                running_sum_reg <= running_sum_next;
                bytes_left_reg  <= bytes_left_next;
            end
        end
    end

endmodule

`default_nettype wire

[src/scfe_queue.sv]
// ----------------------------------------------------------------------------
// scfe_queue
// Short descriptor queue decoupling the front from the byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module scfe_queue (
    input  wire              clk,
    input  wire              rst_n,
    input  scfe_pkg::push_t  push,
    input  wire              pop,
    output logic             full,
    output scfe_pkg::head_t  head
);
    import scfe_pkg::*;

    desc_t               entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.desc  = entries[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (push.valid)
            entries[wr_ptr_reg] <= push.desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push.valid && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (!push.valid && do_pop)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

[src/scfe_back.sv]
// ----------------------------------------------------------------------------
// scfe_back
// Expands each descriptor into frame bytes, one byte per output word.
// ----------------------------------------------------------------------------
`default_nettype none

module scfe_back (
    input  wire              clk,
    input  wire              rst_n,
    input  scfe_pkg::head_t  head,
    output logic             pop,
    scfe_result_if.source    result
);
    import scfe_pkg::*;

    typedef enum logic [3:0] {
        PH_NEW,
        PH_HEAD,
        PH_LEN,
        PH_IDX,
        PH_CMD,
        PH_PB,
        PH_SUM,
        PH_TAIL,
        PH_ERR
    } phase_t;

    phase_t            phase_reg;
    phase_t            cur_phase;
    phase_t            phase_next;
    logic              valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              frame_done_reg;
    logic              error_reg;

    logic              out_free;
    logic              emit;
    logic [BYTE_W-1:0] byte_val;
    logic              done_val;
    logic              err_val;

    assign out_free = !valid_reg || result.ready;
    assign emit     = head.valid && out_free;

    always_comb
    begin
        if (phase_reg == PH_NEW)
        begin
            unique case (head.desc.kind)
                KIND_START:   cur_phase = PH_HEAD;
                KIND_PAYLOAD: cur_phase = PH_PB;
                default:      cur_phase = PH_ERR;
            endcase
        end
        else
            cur_phase = phase_reg;
    end

    always_comb
    begin
        phase_next = PH_NEW;
        byte_val   = ERR_BYTE;
        done_val   = 1'b0;
        err_val    = 1'b0;
        unique case (cur_phase)
            PH_HEAD:
            begin
                byte_val   = HEAD_BYTE;
                phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                byte_val   = head.desc.flen;
                phase_next = PH_IDX;
            end
            PH_IDX:
            begin
                byte_val   = head.desc.idx;
                phase_next = PH_CMD;
            end
            PH_CMD:
            begin
                byte_val   = head.desc.cmd;
                phase_next = head.desc.has_pb ? PH_PB : PH_SUM;
            end
            PH_PB:
            begin
                byte_val   = head.desc.pb;
                phase_next = head.desc.last ? PH_SUM : PH_NEW;
            end
            PH_SUM:
            begin
                byte_val   = head.desc.sum;
                phase_next = PH_TAIL;
            end
            PH_TAIL:
            begin
                byte_val   = TAIL_BYTE;
                done_val   = 1'b1;
                phase_next = PH_NEW;
            end
            PH_ERR:
            begin
                byte_val   = ERR_BYTE;
                done_val   = 1'b1;
                err_val    = 1'b1;
                phase_next = PH_NEW;
            end
            default:
            begin
                phase_next = PH_NEW;
            end
        endcase
    end

    // retire the descriptor with its final byte
    assign pop = emit && (phase_next == PH_NEW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_NEW;
            valid_reg      <= 1'b0;
            out_byte_reg   <= '0;
            frame_done_reg <= 1'b0;
            error_reg      <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                phase_reg      <= phase_next;
                valid_reg      <= 1'b1;
                out_byte_reg   <= byte_val;
                frame_done_reg <= done_val;
                error_reg      <= err_val;
            end
            else if (result.ready)
                valid_reg <= 1'b0;
        end
    end

    assign result.valid      = valid_reg;
    assign result.out_byte   = out_byte_reg;
    assign result.frame_done = frame_done_reg;
    assign result.error      = error_reg;

endmodule

`default_nettype wire

[src/serial_command_frame_encoder.sv]
// ----------------------------------------------------------------------------
// serial_command_frame_encoder
// Builds checksummed command frames for a serial link, one byte per word.
// ----------------------------------------------------------------------------
// Each input word is classified on acceptance and costs one output word per
// byte it produces: a continuation word gives its payload byte, or payload,
// checksum and tail on the last one; the first word of a frame gives the
// four header bytes, its payload byte if any, and checksum and tail if the
// frame ends there; an oversize frame gives a single error word. Payload
// bytes therefore stream at one word per cycle while the output is ready,
// set by the single output register; a four-entry descriptor queue absorbs
// the header and trailer bursts, so input ready only drops once that queue
// is full. Configuration writes are always accepted and take effect from
// the next frame start.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_command_frame_encoder (
    input  wire            clk,
    input  wire            rst_n,
    scfe_item_if.sink      item,
    scfe_result_if.source  result,
    scfe_cfg_if.sink       cfg
);
    import scfe_pkg::*;

    // Front to queue: one classified descriptor per accepted input word
    push_t push;
    logic  queue_full;

    // Queue to back: oldest descriptor, dropped once its last byte goes out
    head_t head;
    logic  pop;

    // Hold frame state and registers, classify each accepted word
    scfe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .cfg        (cfg),
        .queue_full (queue_full),
        .push       (push)
    );

    // Decouple classification from byte emission
    scfe_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (queue_full),
        .head  (head)
    );

    // Advance through the bytes of each descriptor into the output register
    scfe_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .result (result)
    );

endmodule

`default_nettype wire
